>>> src/bpfb_pkg.sv
package bpfb_pkg;

    localparam int MAX_COLUMNS  = 128;
    localparam int MAX_ROWS     = 64;
    localparam int BUFFER_BYTES = 1024;

    localparam int COL_W       = 8;
    localparam int ROW_W       = 7;
    localparam int COORD_W     = 8;
    // wide enough for any byte address and for BUFFER_BYTES up to 8192
    localparam int WIDE_ADDR_W = 14;
    localparam int IN_DATA_W   = 40;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 1'd1;

    localparam logic [COL_W-1:0] COLUMN_COUNT_RESET = 8'd128;
    localparam logic [ROW_W-1:0] ROW_COUNT_RESET    = 7'd64;

    localparam logic [7:0] PIXEL_MSB = 8'h80;

    typedef enum logic [1:0] {
        MODE_WRITE_POINT = 2'd0,
        MODE_READ_POINT  = 2'd1,
        MODE_FILL_RECT   = 2'd2,
        MODE_CLEAR       = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REQ_NOP  = 2'd0,
        REQ_READ = 2'd1,
        REQ_RMW  = 2'd2,
        REQ_ZERO = 2'd3
    } req_op_t;

    typedef enum logic [1:0] {
        WK_SWEEP = 2'd0,
        WK_IDLE  = 2'd1,
        WK_FILL  = 2'd2,
        WK_CLEAR = 2'd3
    } walk_state_t;

    // one byte access handed down the read-modify-write pipe
    typedef struct packed {
        logic                   valid;
        req_op_t                op;
        logic [WIDE_ADDR_W-1:0] addr;
        logic [7:0]             mask;
        logic                   value;
        logic                   ok;
        logic                   last;
    } req_t;

    typedef struct packed {
        logic valid;
        logic read_bit;
        logic ok;
    } done_t;

endpackage

>>> src/bit_packed_led_frame_buffer.sv
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  tdata: x_low, y_low, x_high, y_high, pixel_on
//                                          tuser: mode
// m_       out        m_tvalid / m_tready  tdata: read_bit; tuser: coordinate_ok
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// Point read or write: request reg, RMW reg, output reg; next word once both stages empty.
// Fill and clear send a request per touched or cleared byte; an empty one acts as a point.
// Pace is set by the frame RAM: one read and one write port, one byte per cycle.
// After reset a clearing pass zeroes all BUFFER_BYTES bytes (1024 by default), one per cycle;
// s_tready stays low meanwhile, config writes are taken.
// One finished result may wait in a holding slot behind m_; input stalls once both are full.
module bit_packed_led_frame_buffer #(
    parameter int BUFFER_BYTES = bpfb_pkg::BUFFER_BYTES
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] x_low, [15:8] y_low, [23:16] x_high, [31:24] y_high, [32] pixel_on
    input  logic [bpfb_pkg::IN_DATA_W-1:0]   s_tdata,
    // [1:0] mode
    input  logic [bpfb_pkg::IN_USER_W-1:0]   s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] read_bit
    output logic [bpfb_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [0] coordinate_ok
    output logic                             m_tuser,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpfb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(BUFFER_BYTES);

    logic [bpfb_pkg::COL_W-1:0] column_count_reg;
    logic [bpfb_pkg::ROW_W-1:0] row_count_reg;
    logic [bpfb_pkg::COL_W-1:0] cols_eff;
    logic [bpfb_pkg::ROW_W-1:0] rows_eff;

    logic             accept;
    logic             walker_idle;
    logic             rmw_busy;
    bpfb_pkg::req_t   req_a;
    bpfb_pkg::done_t  done;
    logic             we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [7:0]       rdata;

    logic out_valid_reg, out_valid_next;
    logic out_read_reg, out_read_next;
    logic out_ok_reg, out_ok_next;
    logic pend_valid_reg, pend_valid_next;
    logic pend_read_reg, pend_read_next;
    logic pend_ok_reg, pend_ok_next;
    logic out_free;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= bpfb_pkg::COLUMN_COUNT_RESET;
            row_count_reg    <= bpfb_pkg::ROW_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bpfb_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                bpfb_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_data[bpfb_pkg::ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cols_eff = (column_count_reg < 8'(bpfb_pkg::MAX_COLUMNS))
                      ? column_count_reg : 8'(bpfb_pkg::MAX_COLUMNS);
    assign rows_eff = ({1'b0, row_count_reg} < 8'(bpfb_pkg::MAX_ROWS))
                      ? row_count_reg : 7'(bpfb_pkg::MAX_ROWS);

    // one command in flight at a time
    assign s_tready = walker_idle && !req_a.valid && !rmw_busy && !pend_valid_reg;
    assign accept   = s_tvalid && s_tready;

    bpfb_walker #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .mode     (bpfb_pkg::mode_t'(s_tuser)),
        .x_low    (s_tdata[7:0]),
        .y_low    (s_tdata[15:8]),
        .x_high   (s_tdata[23:16]),
        .y_high   (s_tdata[31:24]),
        .pixel_on (s_tdata[32]),
        .cols     (cols_eff),
        .rows     (rows_eff),
        .idle     (walker_idle),
        .req      (req_a)
    );

    bpfb_ram #(
        .DEPTH(BUFFER_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (req_a.addr[ADDR_W-1:0]),
        .rdata (rdata)
    );

    bpfb_rmw #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_rmw (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_a   (req_a),
        .rd_data (rdata),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .done    (done),
        .busy    (rmw_busy)
    );

    // output register with one holding slot behind it
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_read_next   = out_read_reg;
        out_ok_next     = out_ok_reg;
        pend_valid_next = pend_valid_reg;
        pend_read_next  = pend_read_reg;
        pend_ok_next    = pend_ok_reg;
        if (out_free) begin
            if (pend_valid_reg) begin
                out_valid_next  = 1'b1;
                out_read_next   = pend_read_reg;
                out_ok_next     = pend_ok_reg;
                pend_valid_next = 1'b0;
            end else if (done.valid) begin
                out_valid_next = 1'b1;
                out_read_next  = done.read_bit;
                out_ok_next    = done.ok;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (done.valid) begin
            pend_valid_next = 1'b1;
            pend_read_next  = done.read_bit;
            pend_ok_next    = done.ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_read_reg  <= out_read_next;
        out_ok_reg    <= out_ok_next;
        pend_read_reg <= pend_read_next;
        pend_ok_reg   <= pend_ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_read_reg};
    assign m_tuser  = out_ok_reg;

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        done.valid |-> !pend_valid_reg)
        else $error("result finished with holding slot full");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while a command is in flight");

    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> m_tvalid)
        else $error("holding slot full while output register empty");

endmodule

>>> src/bpfb_ram.sv
module bpfb_ram #(
    parameter int DEPTH  = bpfb_pkg::BUFFER_BYTES,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] frame_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            frame_mem[waddr] <= wdata;
        end
        rd_data_reg <= frame_mem[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

>>> src/bpfb_walker.sv
module bpfb_walker #(
    parameter int BUFFER_BYTES = bpfb_pkg::BUFFER_BYTES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  bpfb_pkg::mode_t              mode,
    input  logic [bpfb_pkg::COORD_W-1:0] x_low,
    input  logic [bpfb_pkg::COORD_W-1:0] y_low,
    input  logic [bpfb_pkg::COORD_W-1:0] x_high,
    input  logic [bpfb_pkg::COORD_W-1:0] y_high,
    input  logic                         pixel_on,
    input  logic [bpfb_pkg::COL_W-1:0]   cols,
    input  logic [bpfb_pkg::ROW_W-1:0]   rows,
    output logic                         idle,
    output bpfb_pkg::req_t               req
);

    localparam int WA    = bpfb_pkg::WIDE_ADDR_W;
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int PROD_W = bpfb_pkg::COL_W + bpfb_pkg::ROW_W;

    bpfb_pkg::walk_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_last_reg, cnt_last_next;
    logic [7:0]       x_reg, x_next;
    logic [7:0]       x_end_reg, x_end_next;
    logic [3:0]       k_reg, k_next;
    logic [3:0]       k_start_reg, k_start_next;
    logic [3:0]       k_end_reg, k_end_next;
    logic [2:0]       lo_reg, lo_next;
    logic [2:0]       hi_reg, hi_next;
    logic             value_reg, value_next;
    bpfb_pkg::req_t   req_reg, req_next;

    logic [PROD_W-1:0] pt_prod, fl_prod, clr_prod;
    logic [WA-1:0]     pt_addr, fl_addr, clr_bytes;
    logic              pt_ok, fl_in, fl_last, rect_ok;
    logic [7:0]        x_end, y_end;
    logic [2:0]        m_lo, m_hi;
    logic [7:0]        fl_mask;
    logic [CNT_W-1:0]  clr_n;

    // address math for a point, for the current fill byte and for clear length
    always_comb begin
        pt_prod  = PROD_W'(x_low) * PROD_W'(rows);
        pt_addr  = WA'(pt_prod[PROD_W-1:3]) + WA'(y_low[7:3]);
        pt_ok    = (x_low < cols) && (y_low < {1'b0, rows})
                   && (pt_addr < WA'(BUFFER_BYTES));

        fl_prod  = PROD_W'(x_reg) * PROD_W'(rows);
        fl_addr  = WA'(fl_prod[PROD_W-1:3]) + WA'(k_reg);
        fl_in    = fl_addr < WA'(BUFFER_BYTES);
        m_lo     = (k_reg == k_start_reg) ? lo_reg : 3'd0;
        m_hi     = (k_reg == k_end_reg) ? hi_reg : 3'd7;
        fl_mask  = (8'hFF >> m_lo) & (8'hFF << (3'd7 - m_hi));
        fl_last  = (x_reg == x_end_reg) && (k_reg == k_end_reg);

        rect_ok  = (x_low <= x_high) && (y_low <= y_high)
                   && (x_low < cols) && (y_low < {1'b0, rows});
        x_end    = (x_high < cols) ? x_high : cols - 8'd1;
        y_end    = (y_high < {1'b0, rows}) ? y_high : {1'b0, rows - 7'd1};

        clr_prod  = PROD_W'(cols) * PROD_W'(rows);
        clr_bytes = WA'(clr_prod[PROD_W-1:3]);
        clr_n     = (clr_bytes < WA'(BUFFER_BYTES)) ? CNT_W'(clr_bytes)
                                                    : CNT_W'(BUFFER_BYTES);
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cnt_last_next = cnt_last_reg;
        x_next        = x_reg;
        x_end_next    = x_end_reg;
        k_next        = k_reg;
        k_start_next  = k_start_reg;
        k_end_next    = k_end_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        value_next    = value_reg;
        req_next      = '0;
        req_next.op   = bpfb_pkg::REQ_NOP;

        unique case (state_reg)
            bpfb_pkg::WK_SWEEP: begin
                req_next.valid = 1'b1;
                req_next.op    = bpfb_pkg::REQ_ZERO;
                req_next.addr  = WA'(cnt_reg);
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(BUFFER_BYTES - 1)) begin
                    cnt_next   = '0;
                    state_next = bpfb_pkg::WK_IDLE;
                end
            end
            bpfb_pkg::WK_IDLE: begin
                if (start) begin
                    req_next.valid = 1'b1;
                    req_next.last  = 1'b1;
                    req_next.ok    = 1'b1;
                    unique case (mode)
                        bpfb_pkg::MODE_WRITE_POINT: begin
                            req_next.op    = pt_ok ? bpfb_pkg::REQ_RMW : bpfb_pkg::REQ_NOP;
                            req_next.addr  = pt_addr;
                            req_next.mask  = bpfb_pkg::PIXEL_MSB >> y_low[2:0];
                            req_next.value = pixel_on;
                            req_next.ok    = pt_ok;
                        end
                        bpfb_pkg::MODE_READ_POINT: begin
                            req_next.op    = pt_ok ? bpfb_pkg::REQ_READ : bpfb_pkg::REQ_NOP;
                            req_next.addr  = pt_addr;
                            req_next.mask  = bpfb_pkg::PIXEL_MSB >> y_low[2:0];
                            req_next.ok    = pt_ok;
                        end
                        bpfb_pkg::MODE_FILL_RECT: begin
                            if (rect_ok) begin
                                req_next.valid = 1'b0;
                                state_next     = bpfb_pkg::WK_FILL;
                                x_next         = x_low;
                                x_end_next     = x_end;
                                k_next         = y_low[6:3];
                                k_start_next   = y_low[6:3];
                                k_end_next     = y_end[6:3];
                                lo_next        = y_low[2:0];
                                hi_next        = y_end[2:0];
                                value_next     = pixel_on;
                            end
                        end
                        bpfb_pkg::MODE_CLEAR: begin
                            if (clr_n != '0) begin
                                req_next.valid = 1'b0;
                                state_next     = bpfb_pkg::WK_CLEAR;
                                cnt_next       = '0;
                                cnt_last_next  = clr_n - CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bpfb_pkg::WK_FILL: begin
                req_next.valid = 1'b1;
                req_next.op    = fl_in ? bpfb_pkg::REQ_RMW : bpfb_pkg::REQ_NOP;
                req_next.addr  = fl_addr;
                req_next.mask  = fl_mask;
                req_next.value = value_reg;
                req_next.ok    = 1'b1;
                req_next.last  = fl_last;
                if (k_reg == k_end_reg) begin
                    k_next = k_start_reg;
                    x_next = x_reg + 8'd1;
                    if (x_reg == x_end_reg) begin
                        state_next = bpfb_pkg::WK_IDLE;
                    end
                end else begin
                    k_next = k_reg + 4'd1;
                end
            end
            bpfb_pkg::WK_CLEAR: begin
                req_next.valid = 1'b1;
                req_next.op    = bpfb_pkg::REQ_ZERO;
                req_next.addr  = WA'(cnt_reg);
                req_next.ok    = 1'b1;
                req_next.last  = (cnt_reg == cnt_last_reg);
                cnt_next       = cnt_reg + CNT_W'(1);
                if (cnt_reg == cnt_last_reg) begin
                    cnt_next   = '0;
                    state_next = bpfb_pkg::WK_IDLE;
                end
            end
            default: begin
                state_next = bpfb_pkg::WK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpfb_pkg::WK_SWEEP;
            cnt_reg   <= '0;
            req_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            req_reg   <= req_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_last_reg <= cnt_last_next;
        x_reg        <= x_next;
        x_end_reg    <= x_end_next;
        k_reg        <= k_next;
        k_start_reg  <= k_start_next;
        k_end_reg    <= k_end_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        value_reg    <= value_next;
    end

    assign idle = (state_reg == bpfb_pkg::WK_IDLE);
    assign req  = req_reg;

    // the closing word of a command leaves the walker free
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req_reg.valid && req_reg.last |-> state_reg == bpfb_pkg::WK_IDLE)
        else $error("last word issued while walker still busy");

endmodule

>>> src/bpfb_rmw.sv
module bpfb_rmw #(
    parameter int BUFFER_BYTES = bpfb_pkg::BUFFER_BYTES,
    parameter int ADDR_W       = $clog2(BUFFER_BYTES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bpfb_pkg::req_t    req_a,
    input  logic [7:0]        rd_data,
    output logic              we,
    output logic [ADDR_W-1:0] waddr,
    output logic [7:0]        wdata,
    output bpfb_pkg::done_t   done,
    output logic              busy
);

    bpfb_pkg::req_t    req_b_reg;
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [7:0]        fwd_data_reg;
    logic [7:0]        base, merged;
    logic              is_zero;

    always_comb begin
        // RAM read raced the previous write to the same byte
        base    = (fwd_valid_reg && fwd_addr_reg == req_b_reg.addr[ADDR_W-1:0])
                  ? fwd_data_reg : rd_data;
        merged  = req_b_reg.value ? (base | req_b_reg.mask) : (base & ~req_b_reg.mask);
        is_zero = req_b_reg.op == bpfb_pkg::REQ_ZERO;
        we      = req_b_reg.valid && (is_zero || req_b_reg.op == bpfb_pkg::REQ_RMW);
        waddr   = req_b_reg.addr[ADDR_W-1:0];
        wdata   = is_zero ? 8'h00 : merged;

        done.valid    = req_b_reg.valid && req_b_reg.last;
        done.read_bit = (req_b_reg.op == bpfb_pkg::REQ_READ) && (|(base & req_b_reg.mask));
        done.ok       = req_b_reg.ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_b_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            req_b_reg     <= req_a;
            fwd_valid_reg <= we;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= waddr;
        fwd_data_reg <= wdata;
    end

    assign busy = req_b_reg.valid;

endmodule
